// ===== hw/rtl/max_pool_2d_top_macros.svh =====
// Assertion macros for the 2-D max pooling block.
`ifndef MAX_POOL_2D_TOP_MACROS_SVH
`define MAX_POOL_2D_TOP_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define MP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("max_pool_2d assertion failed");

// Condition must never be true outside reset.
`define MP_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("max_pool_2d forbidden condition seen");

`endif

// ===== hw/rtl/mp2d_pkg.sv =====
// Shared types and constants of the 2-D max pooling block.
package mp2d_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_COUNT     = 3'd4;

    localparam int MAP_WIDTH_W  = 11;
    localparam int MAP_HEIGHT_W = 11;
    localparam int WINDOW_W     = 4;
    localparam int MAP_COUNT_W  = 5;

    localparam int HEIGHT_LIMIT = 1024;
    localparam int ROW_W        = 10;

    localparam logic signed [31:0] FLOOR_Q16 = -32'sd65536000;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_LVL_W = 3;

    typedef struct packed {
        logic in_window;
        logic first;
        logic last;
        logic plane_last;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] pooled;
        logic               plane_done;
    } res_t;

endpackage

// ===== hw/rtl/mp2d_ctrl.sv =====
// Configuration registers and raster position counters.
module mp2d_ctrl #(
    parameter int MAX_MAP_WIDTH = 1024,
    parameter int MAX_WINDOW    = 8,
    parameter int MAX_MAPS      = 16,
    parameter int ADDR_W        = (MAX_MAP_WIDTH > 1) ? $clog2(MAX_MAP_WIDTH) : 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [mp2d_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [mp2d_pkg::CFG_DATA_W-1:0]  wr_data,
    input  logic                             acc,
    output mp2d_pkg::cmd_t                   cmd,
    output logic [ADDR_W-1:0]                addr
);
    import mp2d_pkg::*;

    localparam int WIN_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int MAP_W = (MAX_MAPS > 1) ? $clog2(MAX_MAPS) : 1;
    localparam int WW_W  = $clog2(MAX_WINDOW + 1);
    localparam int MC_W  = $clog2(MAX_MAPS + 1);
    localparam int MW_W  = $clog2(MAX_MAP_WIDTH + 1);
    localparam int MH_W  = $clog2(HEIGHT_LIMIT + 1);
    localparam int CW    = $clog2(MAX_MAP_WIDTH + 2 * MAX_WINDOW + 1);
    localparam int RW    = $clog2(HEIGHT_LIMIT + 2 * MAX_WINDOW + 1);

    function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
        int unsigned r;
        r = v;
        if (v < 1) r = 1;
        else if (v > hi) r = hi;
        return r;
    endfunction

    logic [MAP_WIDTH_W-1:0]  map_width_reg;
    logic [MAP_HEIGHT_W-1:0] map_height_reg;
    logic [WINDOW_W-1:0]     window_width_reg;
    logic [WINDOW_W-1:0]     window_height_reg;
    logic [MAP_COUNT_W-1:0]  map_count_reg;

    logic [MAP_W-1:0]  map_cnt_reg;
    logic [ADDR_W-1:0] col_reg;
    logic [ADDR_W-1:0] col_start_reg;
    logic [ADDR_W-1:0] cell_col_reg;
    logic [WIN_W-1:0]  win_col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_start_reg;
    logic [WIN_W-1:0]  win_row_reg;

    logic [MW_W-1:0] mw;
    logic [MH_W-1:0] mh;
    logic [WW_W-1:0] ww;
    logic [WW_W-1:0] wh;
    logic [MC_W-1:0] mc;

    logic [CW-1:0] col_end;
    logic [RW-1:0] row_end;
    logic          cfg_hit;
    logic          map_wrap;
    logic          win_col_wrap;
    logic          col_wrap;
    logic          win_row_wrap;
    logic          row_wrap;

    always_comb
    begin
        mw = MW_W'(clamp_cfg(32'(map_width_reg), MAX_MAP_WIDTH));
        mh = MH_W'(clamp_cfg(32'(map_height_reg), HEIGHT_LIMIT));
        ww = WW_W'(clamp_cfg(32'(window_width_reg), MAX_WINDOW));
        wh = WW_W'(clamp_cfg(32'(window_height_reg), MAX_WINDOW));
        mc = MC_W'(clamp_cfg(32'(map_count_reg), MAX_MAPS));
    end

    assign col_end = CW'(col_start_reg) + CW'(ww);
    assign row_end = RW'(row_start_reg) + RW'(wh);

    assign cmd.in_window  = (col_end <= CW'(mw)) && (row_end <= RW'(mh));
    assign cmd.first      = (map_cnt_reg == '0) && (win_col_reg == '0) && (win_row_reg == '0);
    assign cmd.last       = (32'(map_cnt_reg) + 32'd1 == 32'(mc))
                         && (32'(win_col_reg) + 32'd1 == 32'(ww))
                         && (32'(win_row_reg) + 32'd1 == 32'(wh));
    // Last cell when no further whole window fits in either direction.
    assign cmd.plane_last = (col_end + CW'(ww) > CW'(mw)) && (row_end + RW'(wh) > RW'(mh));
    assign addr           = cell_col_reg;

    assign map_wrap     = 32'(map_cnt_reg) + 32'd1 >= 32'(mc);
    assign win_col_wrap = 32'(win_col_reg) + 32'd1 >= 32'(ww);
    assign col_wrap     = 32'(col_reg) + 32'd1 >= 32'(mw);
    assign win_row_wrap = 32'(win_row_reg) + 32'd1 >= 32'(wh);
    assign row_wrap     = 32'(row_reg) + 32'd1 >= 32'(mh);

    assign cfg_hit = wr_en && ((wr_index == REG_MAP_WIDTH) || (wr_index == REG_MAP_HEIGHT)
                   || (wr_index == REG_WINDOW_WIDTH) || (wr_index == REG_WINDOW_HEIGHT)
                   || (wr_index == REG_MAP_COUNT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg     <= MAP_WIDTH_W'(1);
            map_height_reg    <= MAP_HEIGHT_W'(1);
            window_width_reg  <= WINDOW_W'(2);
            window_height_reg <= WINDOW_W'(2);
            map_count_reg     <= MAP_COUNT_W'(1);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_MAP_WIDTH:     map_width_reg     <= wr_data[MAP_WIDTH_W-1:0];
                REG_MAP_HEIGHT:    map_height_reg    <= wr_data[MAP_HEIGHT_W-1:0];
                REG_WINDOW_WIDTH:  window_width_reg  <= wr_data[WINDOW_W-1:0];
                REG_WINDOW_HEIGHT: window_height_reg <= wr_data[WINDOW_W-1:0];
                REG_MAP_COUNT:     map_count_reg     <= wr_data[MAP_COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_cnt_reg   <= '0;
            col_reg       <= '0;
            col_start_reg <= '0;
            cell_col_reg  <= '0;
            win_col_reg   <= '0;
            row_reg       <= '0;
            row_start_reg <= '0;
            win_row_reg   <= '0;
        end
        else if (cfg_hit)
        begin
            // Restart the frame; the row buffer keeps its contents.
            map_cnt_reg   <= '0;
            col_reg       <= '0;
            col_start_reg <= '0;
            cell_col_reg  <= '0;
            win_col_reg   <= '0;
            row_reg       <= '0;
            row_start_reg <= '0;
            win_row_reg   <= '0;
        end
        else if (acc)
        begin
            if (!map_wrap)
            begin
                map_cnt_reg <= map_cnt_reg + MAP_W'(1);
            end
            else
            begin
                map_cnt_reg <= '0;
                if (col_wrap)
                begin
                    col_reg       <= '0;
                    col_start_reg <= '0;
                    cell_col_reg  <= '0;
                    win_col_reg   <= '0;
                    if (row_wrap)
                    begin
                        row_reg       <= '0;
                        row_start_reg <= '0;
                        win_row_reg   <= '0;
                    end
                    else
                    begin
                        row_reg <= row_reg + ROW_W'(1);
                        if (win_row_wrap)
                        begin
                            win_row_reg   <= '0;
                            row_start_reg <= row_reg + ROW_W'(1);
                        end
                        else
                        begin
                            win_row_reg <= win_row_reg + WIN_W'(1);
                        end
                    end
                end
                else
                begin
                    col_reg <= col_reg + ADDR_W'(1);
                    if (win_col_wrap)
                    begin
                        win_col_reg   <= '0;
                        col_start_reg <= col_reg + ADDR_W'(1);
                        cell_col_reg  <= cell_col_reg + ADDR_W'(1);
                    end
                    else
                    begin
                        win_col_reg <= win_col_reg + WIN_W'(1);
                    end
                end
            end
        end
    end

endmodule

// ===== hw/rtl/mp2d_row_buf.sv =====
// Row buffer of running maxima with read-modify-write and forwarding.
module mp2d_row_buf #(
    parameter int MAX_MAP_WIDTH = 1024,
    parameter int ADDR_W        = (MAX_MAP_WIDTH > 1) ? $clog2(MAX_MAP_WIDTH) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               acc,
    input  mp2d_pkg::cmd_t     cmd,
    input  logic [ADDR_W-1:0]  addr,
    input  logic signed [31:0] sample,
    output logic               res_valid,
    output mp2d_pkg::res_t     res
);
    import mp2d_pkg::*;

    logic signed [31:0] mem [MAX_MAP_WIDTH];
    logic signed [31:0] mem_q_reg;

    logic               s1_valid_reg;
    cmd_t               s1_cmd_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic signed [31:0] s1_sample_reg;
    logic               fwd_hit_reg;
    logic signed [31:0] fwd_data_reg;

    logic signed [31:0] base;
    logic signed [31:0] max_val;

    always_comb
    begin
        priority if (s1_cmd_reg.first) base = FLOOR_Q16;
        else if (fwd_hit_reg)          base = fwd_data_reg;
        else                           base = mem_q_reg;
    end

    assign max_val = (s1_sample_reg > base) ? s1_sample_reg : base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= acc && cmd.in_window;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_cmd_reg    <= cmd;
            s1_addr_reg   <= addr;
            s1_sample_reg <= sample;
            // The write in flight this cycle is not yet visible to the read.
            fwd_hit_reg   <= s1_valid_reg && (s1_addr_reg == addr);
            fwd_data_reg  <= max_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            mem_q_reg <= mem[addr];
        end
        if (s1_valid_reg)
        begin
            mem[s1_addr_reg] <= max_val;
        end
    end

    assign res_valid      = s1_valid_reg && s1_cmd_reg.last;
    assign res.pooled     = max_val;
    assign res.plane_done = s1_cmd_reg.plane_last;

endmodule

// ===== hw/rtl/mp2d_out_fifo.sv =====
// Small result queue that decouples the output channel from the pipeline.
module mp2d_out_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  mp2d_pkg::res_t                 din,
    input  logic                           pop,
    output logic                           not_empty,
    output mp2d_pkg::res_t                 dout,
    output logic [mp2d_pkg::OQ_LVL_W-1:0]  level
);
    import mp2d_pkg::*;

    res_t                q_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] head_reg;
    logic [OQ_PTR_W-1:0] tail_reg;
    logic [OQ_LVL_W-1:0] level_reg;
    logic [OQ_LVL_W-1:0] level_next;

    always_comb
    begin
        level_next = level_reg;
        unique case ({push, pop})
            2'b10:   level_next = level_reg + OQ_LVL_W'(1);
            2'b01:   level_next = level_reg - OQ_LVL_W'(1);
            default: level_next = level_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            level_reg <= '0;
        end
        else
        begin
            if (push) tail_reg <= tail_reg + OQ_PTR_W'(1);
            if (pop)  head_reg <= head_reg + OQ_PTR_W'(1);
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[tail_reg] <= din;
        end
    end

    assign not_empty = (level_reg != '0);
    assign dout      = q_reg[head_reg];
    assign level     = level_reg;

endmodule

// ===== hw/rtl/max_pool_2d_top.sv =====
// Top level of the 2-D max pooling block.
// Takes Q16.16 samples in raster order, all maps' samples of a pixel back to back,
// and returns one maximum per whole window (floor -1000.0), the plane's last one
// flagged by plane_done. One sample is taken per clock while in_stall is low: the
// running maximum of a cell lives in a single-port-read row buffer, read at acceptance
// and written back in the following cycle; results pass the sample stage register.
// A four-entry result queue absorbs output stalls; input stall rises only when that
// queue has no room for the results still in flight. A register write restarts the
// frame; no clearing pass is needed since each cell's first sample starts from the floor.
module max_pool_2d_top #(
    parameter int MAX_MAP_WIDTH = 1024,
    parameter int MAX_WINDOW    = 8,
    parameter int MAX_MAPS      = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [mp2d_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [mp2d_pkg::CFG_DATA_W-1:0]  wr_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [31:0]               sample,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [31:0]               pooled,
    output logic                             plane_done
);
    import mp2d_pkg::*;

    `include "max_pool_2d_top_macros.svh"

    localparam int ADDR_W = (MAX_MAP_WIDTH > 1) ? $clog2(MAX_MAP_WIDTH) : 1;

    logic                acc;
    cmd_t                cmd;
    logic [ADDR_W-1:0]   addr;
    logic                res_valid;
    res_t                res;
    res_t                oq_dout;
    logic                pop;
    logic [OQ_LVL_W-1:0] level;

    assign acc = in_valid && !in_stall;
    assign pop = out_valid && !out_stall;

    // Hold input while the queue cannot take the result still in the pipeline.
    assign in_stall = (level == OQ_LVL_W'(OQ_DEPTH))
                   || ((level == OQ_LVL_W'(OQ_DEPTH - 1)) && res_valid);

    mp2d_ctrl #(
        .MAX_MAP_WIDTH (MAX_MAP_WIDTH),
        .MAX_WINDOW    (MAX_WINDOW),
        .MAX_MAPS      (MAX_MAPS),
        .ADDR_W        (ADDR_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .acc      (acc),
        .cmd      (cmd),
        .addr     (addr)
    );

    mp2d_row_buf #(
        .MAX_MAP_WIDTH (MAX_MAP_WIDTH),
        .ADDR_W        (ADDR_W)
    ) u_row_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .cmd       (cmd),
        .addr      (addr),
        .sample    (sample),
        .res_valid (res_valid),
        .res       (res)
    );

    mp2d_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .din       (res),
        .pop       (pop),
        .not_empty (out_valid),
        .dout      (oq_dout),
        .level     (level)
    );

    assign pooled     = oq_dout.pooled;
    assign plane_done = oq_dout.plane_done;

    `MP_NEVER(a_no_overflow, res_valid && !pop && (level == OQ_LVL_W'(OQ_DEPTH)))
    `MP_ASSERT(a_full_stalls, (level == OQ_LVL_W'(OQ_DEPTH)) |-> in_stall)
    `MP_ASSERT(a_drain_last, (pop && (level == OQ_LVL_W'(1)) && !res_valid) |=> !out_valid)

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for max_pool_2d_top: raster sample streams scored against pooled maxima.
module tb;
    import mp2d_pkg::*;

    localparam int MAX_MAP_WIDTH = 1024;
    localparam int MAX_WINDOW    = 8;
    localparam int MAX_MAPS      = 16;

    localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SMIN = 32'sh8000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX = '1;

    localparam int PLAN_ITEMS   = 1800;
    localparam int WIDE_PHASE   = 3;
    localparam int TALL_PHASE   = 9;
    localparam int SETTLE_TICKS = 8;
    localparam int MAX_REPORTS  = 10;

    class pool_tracker;
        int unsigned        map_w, map_h, win_w, win_h, maps;
        logic signed [31:0] row_max [MAX_MAP_WIDTH];
        int unsigned        map_idx, col, row, win_row, win_col;
        res_t               pending_maxima [$];
        int unsigned        mismatches;
        int unsigned        checked;

        function new();
            map_w = 1;
            map_h = 1;
            win_w = 2;
            win_h = 2;
            maps  = 1;
            foreach (row_max[i])
                row_max[i] = FLOOR_Q16;
            mismatches = 0;
            checked    = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            map_idx = 0;
            col     = 0;
            row     = 0;
            win_row = 0;
            win_col = 0;
        endfunction

        function int unsigned clamp_cfg(int unsigned v, int unsigned hi);
            if (v < 1)
                return 1;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function int unsigned frame_samples();
            return clamp_cfg(map_w, MAX_MAP_WIDTH) * clamp_cfg(map_h, HEIGHT_LIMIT) *
                   clamp_cfg(maps, MAX_MAPS);
        endfunction

        function int unsigned pending();
            return pending_maxima.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MAP_WIDTH:     map_w = 32'(data[MAP_WIDTH_W-1:0]);
                REG_MAP_HEIGHT:    map_h = 32'(data[MAP_HEIGHT_W-1:0]);
                REG_WINDOW_WIDTH:  win_w = 32'(data[WINDOW_W-1:0]);
                REG_WINDOW_HEIGHT: win_h = 32'(data[WINDOW_W-1:0]);
                REG_MAP_COUNT:     maps  = 32'(data[MAP_COUNT_W-1:0]);
                default:           return;
            endcase
            restart_frame();
        endfunction

        function void note_sample(logic signed [31:0] s);
            int unsigned        mw, mh, ww, wh, mc, cells_x, cells_y, cx, cy;
            logic signed [31:0] base, m;
            bit                 first, last;
            res_t               r;
            mw = clamp_cfg(map_w, MAX_MAP_WIDTH);
            mh = clamp_cfg(map_h, HEIGHT_LIMIT);
            ww = clamp_cfg(win_w, MAX_WINDOW);
            wh = clamp_cfg(win_h, MAX_WINDOW);
            mc = clamp_cfg(maps, MAX_MAPS);
            cells_x = mw / ww;
            cells_y = mh / wh;
            if (map_idx >= mc || col >= mw || row >= mh || win_col >= ww || win_row >= wh)
                restart_frame();
            if (col < cells_x * ww && row < cells_y * wh)
            begin
                cx = col / ww;
                cy = row / wh;
                first = (map_idx == 0 && win_col == 0 && win_row == 0);
                last  = (map_idx == mc - 1 && win_col == ww - 1 && win_row == wh - 1);
                // every cell starts over from the floor, so stale entries never leak in
                base = first ? FLOOR_Q16 : row_max[cx];
                m = (s > base) ? s : base;
                row_max[cx] = m;
                if (last)
                begin
                    r.pooled     = m;
                    r.plane_done = (cx == cells_x - 1 && cy == cells_y - 1);
                    pending_maxima.push_back(r);
                end
            end
            map_idx++;
            if (map_idx >= mc)
            begin
                map_idx = 0;
                col++;
                win_col++;
                if (win_col >= ww)
                    win_col = 0;
                if (col >= mw)
                begin
                    col = 0;
                    win_col = 0;
                    row++;
                    win_row++;
                    if (win_row >= wh)
                        win_row = 0;
                    if (row >= mh)
                    begin
                        row = 0;
                        win_row = 0;
                    end
                end
            end
        endfunction

        function void check_pooled(logic signed [31:0] got, logic got_done);
            res_t want;
            checked++;
            if (pending_maxima.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: unexpected result pooled=%0d plane_done=%b", got, got_done);
                return;
            end
            want = pending_maxima.pop_front();
            if (want.pooled !== got || want.plane_done !== got_done)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: result %0d: pooled exp %0d got %0d, plane_done exp %b got %b",
                             checked, want.pooled, got, want.plane_done, got_done);
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n    = 1'b0;
    logic                    wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]    wr_index = '0;
    logic [CFG_DATA_W-1:0]   wr_data  = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic signed [31:0]      sample   = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [31:0]      pooled;
    logic                    plane_done;

    pool_tracker tracker;
    int          src_idle_pct  = 31;
    int          sink_idle_pct = 64;
    int          samples_sent  = 0;
    int          cfg_writes    = 0;

    // partial-window frame: 5 x 3 map, 2 x 2 window, one map
    logic signed [31:0] edge_grid [15] = '{
        SMIN, FLOOR_Q16 - 1, 0, 1, SMAX,
        FLOOR_Q16 - 2, SMIN, -1, SMAX, 7,
        SMAX, SMAX, SMAX, SMAX, SMAX
    };
    // two maps, 2 x 1 map, 1 x 1 window, runs past the frame end
    logic signed [31:0] wrap_row [6] = '{
        FLOOR_Q16, FLOOR_Q16 + 1, 1, -1, FLOOR_Q16 - 1, FLOOR_Q16
    };

    max_pool_2d_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pooled     (pooled),
        .plane_done (plane_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < sink_idle_pct);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            tracker.check_pooled(pooled, plane_done);

    task automatic send_sample(input logic signed [31:0] v);
        if (samples_sent < PLAN_ITEMS / 3)
        begin
            src_idle_pct  = 31;
            sink_idle_pct = 64;
        end
        else if (samples_sent < 2 * PLAN_ITEMS / 3)
        begin
            src_idle_pct  = 64;
            sink_idle_pct = 31;
        end
        else
        begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
        end
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= v;
        // hold the transaction until an edge with stall low
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_sample(v);
        samples_sent++;
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        tracker.write_reg(idx, data);
        cfg_writes++;
    endtask

    task automatic end_writes();
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    // drop valid, then wait out results in flight plus samples that produce nothing
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        if ($urandom_range(9) == 0)
            return '0;
        return CFG_DATA_W'($urandom_range(8, 1));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_window();
        case ($urandom_range(9))
            0:       return '0;
            1:       return CFG_DATA_W'(MAX_WINDOW);
            2:       return CFG_DATA_W'($urandom_range(15, MAX_WINDOW + 1));
            default: return CFG_DATA_W'($urandom_range(4, 1));
        endcase
    endfunction

    function automatic logic signed [31:0] draw_sample();
        int off;
        off = $urandom_range(8);
        case ($urandom_range(9))
            0:       return SMAX;
            1:       return SMIN;
            2, 3:    return FLOOR_Q16 + off - 4;
            4:       return off - 4;
            default: return $urandom;
        endcase
    endfunction

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] mw, mh, ww, wh, mc,
                                 input bit all_regs);
        logic [CFG_DATA_W-1:0] vals [5];
        logic [CFG_DATA_W-1:0] junk;
        int                    bits;
        vals[REG_MAP_WIDTH]     = mw;
        vals[REG_MAP_HEIGHT]    = mh;
        vals[REG_WINDOW_WIDTH]  = ww;
        vals[REG_WINDOW_HEIGHT] = wh;
        vals[REG_MAP_COUNT]     = mc;
        for (int r = REG_MAP_WIDTH; r <= REG_MAP_COUNT; r++)
        begin
            if (all_regs || $urandom_range(3) != 0)
            begin
                bits = (r == REG_WINDOW_WIDTH || r == REG_WINDOW_HEIGHT) ? WINDOW_W :
                       (r == REG_MAP_COUNT) ? MAP_COUNT_W : CFG_DATA_W;
                junk = CFG_DATA_W'($urandom);
                // upper bits beyond the register width must be dropped
                if (bits < CFG_DATA_W && $urandom_range(1) == 1)
                    vals[r] = vals[r] | (junk << bits);
                reg_write(CFG_IDX_W'(r), vals[r]);
            end
        end
        if ($urandom_range(9) == 0)
            reg_write(CFG_IDX_W'($urandom_range(REG_LAST_INDEX, REG_MAP_COUNT + 1)),
                      CFG_DATA_W'($urandom));
        end_writes();
    endtask

    task automatic run_random_phase(input int phase_no);
        logic [CFG_DATA_W-1:0] mw, mh, ww, wh, mc;
        int unsigned           frame_len, n;
        bit                    extreme;
        extreme = (phase_no == WIDE_PHASE || phase_no == TALL_PHASE);
        if (phase_no == WIDE_PHASE)
        begin
            mw = CFG_DATA_W'($urandom_range(2047, MAX_MAP_WIDTH));
            mh = CFG_DATA_W'(1);
            ww = CFG_DATA_W'(1);
            wh = CFG_DATA_W'(1);
            mc = CFG_DATA_W'(1);
        end
        else if (phase_no == TALL_PHASE)
        begin
            mw = CFG_DATA_W'(1);
            mh = CFG_DATA_W'($urandom_range(2047, HEIGHT_LIMIT));
            ww = CFG_DATA_W'(1);
            wh = CFG_DATA_W'(MAX_WINDOW);
            mc = CFG_DATA_W'(1);
        end
        else
        begin
            mw = pick_dim();
            mh = pick_dim();
            ww = pick_window();
            wh = pick_window();
            case ($urandom_range(9))
                0:
                begin
                    mc = CFG_DATA_W'(MAX_MAPS);
                    mw = CFG_DATA_W'($urandom_range(4, 1));
                    mh = CFG_DATA_W'($urandom_range(4, 1));
                end
                1:       mc = '0;
                2:
                begin
                    mc = CFG_DATA_W'($urandom_range(31, MAX_MAPS + 1));
                    mw = CFG_DATA_W'($urandom_range(4, 1));
                    mh = CFG_DATA_W'($urandom_range(4, 1));
                end
                default: mc = CFG_DATA_W'($urandom_range(3, 1));
            endcase
        end
        apply_setting(mw, mh, ww, wh, mc, phase_no == 0 || extreme);
        frame_len = tracker.frame_samples();
        if (phase_no == WIDE_PHASE)
            n = frame_len;
        else
        begin
            if (phase_no == TALL_PHASE)
                n = frame_len;
            else
            begin
                case ($urandom_range(9))
                    0, 1, 2: n = $urandom_range(frame_len, 1);
                    3, 4:    n = 2 * frame_len;
                    default: n = frame_len;
                endcase
            end
            // cut oversized frames short; the next write restarts anyway
            if (n > 400)
                n = 400;
        end
        repeat (n) send_sample(draw_sample());
        drain();
    endtask

    initial
    begin
        int phase;
        int guard;
        int leftover;
        tracker = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: map narrower than the window, nothing comes out
        send_sample(SMAX);
        send_sample(SMIN);
        send_sample(0);
        drain();

        reg_write(REG_MAP_WIDTH, CFG_DATA_W'(5));
        reg_write(REG_MAP_HEIGHT, CFG_DATA_W'(3));
        reg_write(REG_WINDOW_WIDTH, CFG_DATA_W'(2));
        reg_write(REG_WINDOW_HEIGHT, CFG_DATA_W'(2));
        reg_write(REG_MAP_COUNT, CFG_DATA_W'(1));
        end_writes();
        foreach (edge_grid[i])
            send_sample(edge_grid[i]);
        drain();

        // zero windows read as one
        reg_write(REG_MAP_WIDTH, CFG_DATA_W'(2));
        reg_write(REG_MAP_HEIGHT, CFG_DATA_W'(1));
        reg_write(REG_WINDOW_WIDTH, CFG_DATA_W'(0));
        reg_write(REG_WINDOW_HEIGHT, CFG_DATA_W'(0));
        reg_write(REG_MAP_COUNT, CFG_DATA_W'(2));
        end_writes();
        foreach (wrap_row[i])
            send_sample(wrap_row[i]);
        drain();

        phase = 0;
        while (samples_sent < PLAN_ITEMS || phase <= TALL_PHASE)
        begin
            run_random_phase(phase);
            phase++;
        end

        guard = 0;
        while (tracker.pending() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_TICKS) @(posedge clk);
        leftover = tracker.pending();
        if (leftover != 0)
            $display("ERROR: %0d expected results never arrived", leftover);

        $display("Sent %0d samples over %0d register settings phases, %0d register writes",
                 samples_sent, phase + 3, cfg_writes);
        $display("Checked %0d pooled results incl. a full 1024-wide frame, %0d mismatches",
                 tracker.checked, tracker.mismatches);
        if (tracker.mismatches == 0 && leftover == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
